@@ rtl/sha_pkg.sv @@
// SHA-256 package: shared types, constants and round functions.
// Used by the controller, the datapath and the top level.
package sha_pkg;

    typedef struct packed {
        logic load_byte;
        logic pad_byte;
        logic clear_rest;
        logic zero_block;
        logic put_length;
        logic start_comp;
        logic round_step;
        logic finish_comp;
        logic reset_hash;
        logic out_load;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] round_idx;
    } sha_stat_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/sha_datapath.sv @@
// SHA-256 datapath: block buffer, schedule window, working variables, hash.
// Depends on sha_pkg; driven by sha_ctrl commands.
module sha_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::sha_cmd_t cmd,
    input  logic [7:0]        data_byte,
    output sha_pkg::sha_stat_t stat,
    output logic [255:0]      digest
);
    import sha_pkg::*;

    logic [31:0] block_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [60:0] count_reg;
    logic [5:0]  round_reg;

    logic [5:0]  pos;
    logic [1:0]  lane;
    logic [3:0]  wi;
    logic [3:0]  slot;
    logic [31:0] w_new, a15, a2, s1, ch, t1, s0, mj;
    logic [63:0] bit_len;

    assign pos  = count_reg[5:0];
    assign lane = pos[1:0];
    assign wi   = pos[5:2];
    assign slot = round_reg[3:0];
    assign bit_len = {count_reg, 3'b000};
    assign stat.pos = pos;
    assign stat.round_idx = round_reg;

    always_comb
    begin
        a15 = w_reg[slot - 4'd15];
        a2  = w_reg[slot - 4'd2];
        if (round_reg < 6'd16)
        begin
            w_new = block_reg[slot];
        end
        else
        begin
            w_new = w_reg[slot] + (rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3))
                  + w_reg[slot - 4'd7] + (rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10));
        end
        s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + K[round_reg] + w_new;
        s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_byte || cmd.pad_byte)
        begin
            if (lane == 2'd0)
                block_reg[wi] <= {(cmd.pad_byte ? PAD_BYTE : data_byte), 24'd0};
            else
                block_reg[wi] <= block_reg[wi] |
                    ({24'd0, (cmd.pad_byte ? PAD_BYTE : data_byte)}
                     << (5'd24 - {lane, 3'b000}));
        end
        if (cmd.clear_rest)
        begin
            for (int i = 0; i < 16; i++)
                if (i > wi)
                    block_reg[i] <= '0;
        end
        if (cmd.zero_block)
        begin
            for (int i = 0; i < 16; i++)
                block_reg[i] <= '0;
        end
        if (cmd.put_length)
        begin
            block_reg[14] <= bit_len[63:32];
            block_reg[15] <= bit_len[31:0];
        end
        if (cmd.start_comp)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        if (cmd.round_step)
        begin
            w_reg[slot] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + s0 + mj;
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < 8; i++)
                digest[255 - 32*i -: 32] <= h_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV[i];
            count_reg <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.load_byte)
                count_reg <= count_reg + 61'd1;
            if (cmd.round_step)
                round_reg <= round_reg + 6'd1;
            if (cmd.finish_comp)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.reset_hash)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= IV[i];
                count_reg <= '0;
            end
        end
    end
endmodule

@@ rtl/sha_ctrl.sv @@
// SHA-256 controller: sequences byte load, padding, rounds and digest output.
// Depends on sha_pkg; drives sha_datapath.
module sha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               byte_present,
    input  logic               last_of_message,
    input  sha_pkg::sha_stat_t stat,
    input  logic               out_free,
    output logic               in_ready,
    output logic               out_start,
    output sha_pkg::sha_cmd_t  cmd
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_LEN   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       two_reg, two_next;
    // A data block completes with count at 0 mod 64 too, so track the length block.
    logic       len_reg, len_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        out_start = 1'b0;
        state_next = state_reg;
        fin_next = fin_reg;
        two_next = two_reg;
        len_next = len_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    fin_next = last_of_message;
                    if (byte_present)
                    begin
                        cmd.load_byte = 1'b1;
                        if (stat.pos == 6'd63)
                        begin
                            cmd.start_comp = 1'b1;
                            state_next = S_ROUND;
                            two_next = 1'b0;
                        end
                        else if (last_of_message)
                            state_next = S_PAD;
                    end
                    else if (last_of_message)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.pad_byte = 1'b1;
                cmd.clear_rest = 1'b1;
                if (stat.pos >= 6'd56)
                begin
                    two_next = 1'b1;
                    cmd.start_comp = 1'b1;
                    state_next = S_ROUND;
                end
                else
                    state_next = S_LEN;
            end
            S_LEN:
            begin
                cmd.put_length = 1'b1;
                cmd.start_comp = 1'b1;
                two_next = 1'b0;
                fin_next = 1'b0;
                len_next = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (stat.round_idx == 6'd63)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish_comp = 1'b1;
                len_next = 1'b0;
                if (two_reg)
                begin
                    cmd.zero_block = 1'b1;
                    state_next = S_LEN;
                end
                else if (fin_reg)
                    state_next = S_PAD;
                else if (len_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.reset_hash = 1'b1;
                    out_start = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            len_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            fin_reg <= fin_next;
            two_reg <= two_next;
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_round_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && stat.round_idx == 6'd63) |=> (state_reg == S_FIN))
        else $error("round sequence did not end at round 63");
    a_fin_round0: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (stat.round_idx == 6'd0))
        else $error("round index not wrapped at finish");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
`endif
endmodule

@@ rtl/sha256_message_digest_unit.sv @@
// SHA-256 message digest unit top level: stream ports, controller,
// datapath and digest output register. Depends on sha_pkg, sha_ctrl, sha_datapath.
//
// A byte item that does not fill a block leaves the input ready, so such items
// can follow back to back. A byte that fills a block holds the input through
// the 64 rounds and the hash update. An item that ends the message holds the
// input through pad, length, rounds, hash update and digest load, plus a further
// block's rounds and hash update when the padding spills into a second block or
// when its own byte fills a block; the digest load waits until the previous
// digest has at most one word left and that word is taken. The eight digest words
// leave from an output register, one per cycle while m_tready is high, once the
// digest and then the shift register are loaded, while the next message is accepted.
module sha256_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // last_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic        m_tlast    // digest_last
);
    import sha_pkg::*;

    sha_cmd_t     cmd;
    sha_stat_t    stat;
    logic [255:0] digest;
    logic [255:0] shift_reg;
    logic [3:0]   left_reg;
    logic         out_start, in_fire, out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = (left_reg == 4'd0) || (left_reg == 4'd1 && m_tready);

    sha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .byte_present(s_tuser), .last_of_message(s_tlast),
        .stat(stat), .out_free(out_free), .in_ready(s_tready),
        .out_start(out_start), .cmd(cmd));

    sha_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(s_tdata),
        .stat(stat), .digest(digest));

    logic start_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            start_d_reg <= 1'b0;
        end
        else
        begin
            start_d_reg <= out_start;
            if (m_tvalid && m_tready)
                left_reg <= left_reg - 4'd1;
            if (start_d_reg)
                left_reg <= 4'd8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_d_reg)
            shift_reg <= digest;
        else if (m_tvalid && m_tready)
            shift_reg <= {shift_reg[223:0], 32'd0};
    end

    assign m_tvalid = (left_reg != 4'd0);
    assign m_tdata  = shift_reg[255:224];
    assign m_tlast  = (left_reg == 4'd1);

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 4'd8)
        else $error("output count out of range");
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        start_d_reg |-> (left_reg == 4'd0 || (left_reg == 4'd1 && m_tready)))
        else $error("digest overwritten before sent");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || left_reg == 4'd8))
        else $error("extra word after last");
`endif
endmodule
